// ===== hw/rtl/heading_differential_drive_assert.svh =====
// Assertion macros for the heading differential drive block.
// Included by the top level; expects i_clk and i_rst_n in scope.
`ifndef HEADING_DIFFERENTIAL_DRIVE_ASSERT_SVH
`define HEADING_DIFFERENTIAL_DRIVE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HDD_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HDD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/hdd_pkg.sv =====
// Shared types and constants of the heading differential drive block.
// Used by hdd_ctrl, hdd_datapath and the top level; depends on nothing.
package hdd_pkg;

    localparam logic signed [27:0] PI_Q24      = 28'sd52707179;
    localparam logic signed [27:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [35:0] GAIN_Q30    = 36'sd652032874;
    localparam logic [16:0]        FULL_DRIVE  = 17'd32768;
    localparam int                 DIV_STEPS   = 16;

    typedef struct packed {
        logic load;
        logic atan_step;
        logic head;
        logic sc_init;
        logic sc_step;
        logic sc_fin;
        logic drive;
        logic mul_l;
        logic mul_r;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic iter_last;
        logic div_last;
    } t_dp_sts;

    // atan(2^-i) in radians, Q.24.
    function automatic logic [23:0] atan_q24(input logic [4:0] idx);
        logic [23:0] v;
        case (idx)
            5'd0:  v = 24'd13176795;
            5'd1:  v = 24'd7778716;
            5'd2:  v = 24'd4110060;
            5'd3:  v = 24'd2086331;
            5'd4:  v = 24'd1047214;
            5'd5:  v = 24'd524117;
            5'd6:  v = 24'd262123;
            5'd7:  v = 24'd131069;
            5'd8:  v = 24'd65536;
            5'd9:  v = 24'd32768;
            5'd10: v = 24'd16384;
            5'd11: v = 24'd8192;
            5'd12: v = 24'd4096;
            5'd13: v = 24'd2048;
            5'd14: v = 24'd1024;
            5'd15: v = 24'd512;
            5'd16: v = 24'd256;
            5'd17: v = 24'd128;
            5'd18: v = 24'd64;
            5'd19: v = 24'd32;
            5'd20: v = 24'd16;
            5'd21: v = 24'd8;
            5'd22: v = 24'd4;
            5'd23: v = 24'd2;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/hdd_datapath.sv =====
// Datapath: shared CORDIC unit (vectoring and rotation), drive rule and
// a restoring divider for the slow-start ramp. Depends on hdd_pkg.
module hdd_datapath #(
    parameter int ITER = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hdd_pkg::t_dp_cmd      i_cmd,
    output hdd_pkg::t_dp_sts      o_sts,
    input  logic signed [15:0]    i_heading_x,
    input  logic signed [15:0]    i_heading_y,
    input  logic signed [15:0]    i_sway,
    input  logic [15:0]           i_ramp_steps,
    input  logic [12:0]           i_correction_cap,
    input  logic [15:0]           i_sway_gain,
    input  logic [15:0]           i_drive_boost,
    output logic [15:0]           o_left_drive,
    output logic [15:0]           o_right_drive
);

    localparam int IW = $clog2(ITER);
    localparam logic [IW-1:0] ITER_LAST = IW'(ITER - 1);
    localparam logic [3:0]    DIV_LAST  = 4'(hdd_pkg::DIV_STEPS - 1);

    // control state
    logic [IW-1:0]       r_iter;
    logic [3:0]          r_dcnt;
    logic signed [15:0]  r_prev;
    logic [15:0]         r_tick;

    // payload
    logic signed [35:0]  r_cx, r_cy;
    logic signed [27:0]  r_cz;
    logic                r_vec, r_zero, r_neg, r_c_pos, r_bypass;
    logic signed [33:0]  r_prod;
    logic signed [16:0]  r_corr;
    logic signed [15:0]  r_head;
    logic [16:0]         r_s_drv, r_left, r_right;
    logic [15:0]         r_t, r_rem, r_dq, r_left_q, r_out_left, r_out_right;

    // CORDIC step
    logic signed [35:0]  w_sx, w_sy, w_nx, w_ny;
    logic signed [27:0]  w_a, w_nz;
    logic                w_up;

    always_comb begin
        w_sx = r_cx >>> r_iter;
        w_sy = r_cy >>> r_iter;
        w_a  = $signed({4'b0000, hdd_pkg::atan_q24(5'(r_iter))});
        // Vectoring drives y to zero, rotation drives z to zero.
        w_up = r_vec ? (r_cy > 36'sd0) : (r_cz < 28'sd0);
        if (w_up) begin
            w_nx = r_cx + w_sy;
            w_ny = r_cy - w_sx;
            w_nz = r_cz + w_a;
        end else begin
            w_nx = r_cx - w_sy;
            w_ny = r_cy + w_sx;
            w_nz = r_cz - w_a;
        end
    end

    // Load: fold the left half plane onto the right one.
    logic signed [35:0]  w_hx, w_hy, w_x0, w_y0;
    logic signed [27:0]  w_z0;
    logic signed [33:0]  w_prod;

    always_comb begin
        w_hx = {{20{i_heading_x[15]}}, i_heading_x};
        w_hy = {{20{i_heading_y[15]}}, i_heading_y};
        if (w_hx < 36'sd0) begin
            w_x0 = (-w_hx) <<< 16;
            w_y0 = (-w_hy) <<< 16;
            w_z0 = (w_hy >= 36'sd0) ? hdd_pkg::PI_Q24 : -hdd_pkg::PI_Q24;
        end else begin
            w_x0 = w_hx <<< 16;
            w_y0 = w_hy <<< 16;
            w_z0 = 28'sd0;
        end
        w_prod = i_sway * $signed({1'b0, i_sway_gain});
    end

    // Correction and corrected heading.
    logic signed [33:0]  w_round;
    logic signed [16:0]  w_corr_raw, w_cap, w_corr;
    logic signed [27:0]  w_ang_sum, w_ang_sh;
    logic signed [16:0]  w_ang;
    logic signed [17:0]  w_head_full;
    logic signed [15:0]  w_head;

    always_comb begin
        w_round    = (r_prod + 34'sd65536) >>> 17;
        w_corr_raw = w_round[16:0];
        w_cap      = $signed({4'b0000, i_correction_cap});
        w_corr     = (w_corr_raw > w_cap) ? w_cap : w_corr_raw;
        w_ang_sum  = r_cz + 28'sd1024;
        w_ang_sh   = w_ang_sum >>> 11;
        w_ang      = r_zero ? 17'sd0 : w_ang_sh[16:0];
        w_head_full = {w_ang[16], w_ang} - {r_corr[16], r_corr};
        if (w_head_full > 18'sd32767) begin
            w_head = 16'sd32767;
        end else if (w_head_full < -18'sd32768) begin
            w_head = -16'sd32768;
        end else begin
            w_head = w_head_full[15:0];
        end
    end

    // Rotation start: bring the angle into the right half plane.
    logic signed [27:0]  w_zh, w_zs;
    logic                w_fold;

    always_comb begin
        w_zh = {r_head[15], r_head, 11'b0};
        if (w_zh > hdd_pkg::HALF_PI_Q24) begin
            w_zs   = w_zh - hdd_pkg::PI_Q24;
            w_fold = 1'b1;
        end else if (w_zh < -hdd_pkg::HALF_PI_Q24) begin
            w_zs   = w_zh + hdd_pkg::PI_Q24;
            w_fold = 1'b1;
        end else begin
            w_zs   = w_zh;
            w_fold = 1'b0;
        end
    end

    // Sine and cosine rounded to Q1.15.
    logic signed [35:0]  w_xf, w_yf, w_cr, w_sr, w_s;
    logic [16:0]         w_s_drv;

    always_comb begin
        w_xf = r_neg ? -r_cx : r_cx;
        w_yf = r_neg ? -r_cy : r_cy;
        w_cr = w_xf + 36'sd16384;
        w_sr = w_yf + 36'sd16384;
        w_s  = w_sr >>> 15;
        if (w_s < 36'sd0) begin
            w_s_drv = 17'd0;
        end else if (w_s > 36'sd32768) begin
            w_s_drv = hdd_pkg::FULL_DRIVE;
        end else begin
            w_s_drv = w_s[16:0];
        end
    end

    // Drive rule and ramp position.
    logic [17:0]         w_sum;
    logic [16:0]         w_boosted, w_left, w_right;
    logic [15:0]         w_t, w_tick;
    logic [16:0]         w_t1;

    always_comb begin
        w_sum     = {1'b0, r_s_drv} + {2'b00, i_drive_boost};
        w_boosted = (w_sum > {1'b0, hdd_pkg::FULL_DRIVE}) ? hdd_pkg::FULL_DRIVE : w_sum[16:0];
        if (r_c_pos) begin
            w_right = r_s_drv;
            w_left  = (r_prev >= r_head) ? hdd_pkg::FULL_DRIVE : w_boosted;
        end else begin
            w_left  = r_s_drv;
            w_right = (r_prev < r_head) ? hdd_pkg::FULL_DRIVE : w_boosted;
        end
        w_t  = (r_tick < i_ramp_steps) ? r_tick : i_ramp_steps;
        w_t1 = {1'b0, w_t} + 17'd1;
        if (i_ramp_steps == 16'd0) begin
            w_tick = 16'd0;
        end else if (w_t1 < {1'b0, i_ramp_steps}) begin
            w_tick = w_t1[15:0];
        end else begin
            w_tick = i_ramp_steps;
        end
    end

    // Ramp scaling: multiply, then one quotient bit per cycle.
    logic [16:0]         w_mul_src, w_trial, w_diff;
    logic [32:0]         w_mul;
    logic                w_ge;

    always_comb begin
        w_mul_src = i_cmd.mul_r ? r_right : r_left;
        w_mul     = w_mul_src * r_t;
        w_trial   = {r_rem, r_dq[15]};
        w_ge      = (w_trial >= {1'b0, i_ramp_steps});
        w_diff    = w_trial - {1'b0, i_ramp_steps};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter <= '0;
            r_dcnt <= '0;
            r_prev <= '0;
            r_tick <= '0;
        end else begin
            if (i_cmd.load || i_cmd.sc_init) begin
                r_iter <= '0;
            end else if (i_cmd.atan_step || i_cmd.sc_step) begin
                r_iter <= r_iter + 1'b1;
            end
            if (i_cmd.mul_l || i_cmd.mul_r) begin
                r_dcnt <= '0;
            end else if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt + 4'd1;
            end
            if (i_cmd.drive) begin
                r_prev <= r_head;
                r_tick <= w_tick;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx   <= w_x0;
            r_cy   <= w_y0;
            r_cz   <= w_z0;
            r_vec  <= 1'b1;
            r_zero <= (i_heading_x == 16'sd0) && (i_heading_y == 16'sd0);
            r_prod <= w_prod;
        end
        if (i_cmd.atan_step || i_cmd.sc_step) begin
            r_cx <= w_nx;
            r_cy <= w_ny;
            r_cz <= w_nz;
        end
        if (i_cmd.atan_step) begin
            r_corr <= w_corr;
        end
        if (i_cmd.head) begin
            r_head <= w_head;
        end
        if (i_cmd.sc_init) begin
            r_cx  <= hdd_pkg::GAIN_Q30;
            r_cy  <= 36'sd0;
            r_cz  <= w_zs;
            r_vec <= 1'b0;
            r_neg <= w_fold;
        end
        if (i_cmd.sc_fin) begin
            r_c_pos <= (w_cr >= 36'sd32768);
            r_s_drv <= w_s_drv;
        end
        if (i_cmd.drive) begin
            r_left   <= w_left;
            r_right  <= w_right;
            r_t      <= w_t;
            r_bypass <= (i_ramp_steps == 16'd0);
        end
        if (i_cmd.mul_l || i_cmd.mul_r) begin
            r_rem <= w_mul[31:16];
            r_dq  <= w_mul[15:0];
        end
        if (i_cmd.mul_r) begin
            r_left_q <= r_dq;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_diff[15:0] : w_trial[15:0];
            r_dq  <= {r_dq[14:0], w_ge};
        end
        if (i_cmd.out_load) begin
            r_out_left  <= r_bypass ? r_left[15:0] : r_left_q;
            r_out_right <= r_bypass ? r_right[15:0] : r_dq;
        end
    end

    assign o_sts.iter_last = (r_iter == ITER_LAST);
    assign o_sts.div_last  = (r_dcnt == DIV_LAST);
    assign o_left_drive    = r_out_left;
    assign o_right_drive   = r_out_right;

endmodule

// ===== hw/rtl/hdd_ctrl.sv =====
// Controller: sequences one transaction through the datapath and owns
// the input stall and the result valid. Depends on hdd_pkg.
module hdd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  hdd_pkg::t_dp_sts  i_sts,
    output hdd_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ATAN,
        S_HEAD,
        S_SC_INIT,
        S_SC,
        S_SC_FIN,
        S_DRIVE,
        S_MUL_L,
        S_DIV_L,
        S_MUL_R,
        S_DIV_R,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   w_out_free;

    // The result register may be overwritten once its transaction goes.
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ATAN;
                end
            end
            S_ATAN: begin
                o_cmd.atan_step = 1'b1;
                if (i_sts.iter_last) n_state = S_HEAD;
            end
            S_HEAD: begin
                o_cmd.head = 1'b1;
                n_state    = S_SC_INIT;
            end
            S_SC_INIT: begin
                o_cmd.sc_init = 1'b1;
                n_state       = S_SC;
            end
            S_SC: begin
                o_cmd.sc_step = 1'b1;
                if (i_sts.iter_last) n_state = S_SC_FIN;
            end
            S_SC_FIN: begin
                o_cmd.sc_fin = 1'b1;
                n_state      = S_DRIVE;
            end
            S_DRIVE: begin
                o_cmd.drive = 1'b1;
                n_state     = S_MUL_L;
            end
            S_MUL_L: begin
                o_cmd.mul_l = 1'b1;
                n_state     = S_DIV_L;
            end
            S_DIV_L: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_MUL_R;
            end
            S_MUL_R: begin
                o_cmd.mul_r = 1'b1;
                n_state     = S_DIV_R;
            end
            S_DIV_R: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/heading_differential_drive.sv =====
// Top level of the heading differential drive block: register file,
// controller and datapath. Depends on hdd_pkg, hdd_ctrl, hdd_datapath.
//
//  Channel   Handshake                 Payload
//  input     i_in_valid / o_in_stall   i_heading_x, i_heading_y, i_sway
//  result    o_out_valid / i_out_stall o_left_drive, o_right_drive
//  config    psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// A result is valid once the controller leaves its last state; the next input is taken
// only when the controller is back in idle. The shared CORDIC unit runs twice, vectoring
// and then rotation, then the ramp divider runs once for each of the two drives.
// A result waits in the output register while the next input is taken; the one after
// it holds in the last state, input stalled, until that register is free.
// Reset is synchronous and active low; it restores the registers and clears the state.
`include "heading_differential_drive_assert.svh"

module heading_differential_drive #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_heading_x,
    input  logic signed [15:0] i_heading_y,
    input  logic signed [15:0] i_sway,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [15:0]        o_left_drive,
    output logic [15:0]        o_right_drive,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [1:0] {
        REG_RAMP_STEPS     = 2'd0,
        REG_CORRECTION_CAP = 2'd1,
        REG_SWAY_GAIN      = 2'd2,
        REG_DRIVE_BOOST    = 2'd3
    } t_reg_idx;

    logic [15:0] r_ramp_steps;
    logic [12:0] r_correction_cap;
    logic [15:0] r_sway_gain;
    logic [15:0] r_drive_boost;
    logic        w_wr;
    t_reg_idx    w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_steps     <= 16'd10000;
            r_correction_cap <= 13'd858;
            r_sway_gain      <= 16'd11438;
            r_drive_boost    <= 16'd9830;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_RAMP_STEPS:     r_ramp_steps     <= pwdata[15:0];
                REG_CORRECTION_CAP: r_correction_cap <= pwdata[12:0];
                REG_SWAY_GAIN:      r_sway_gain      <= pwdata[15:0];
                REG_DRIVE_BOOST:    r_drive_boost    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_RAMP_STEPS:     prdata = {16'd0, r_ramp_steps};
            REG_CORRECTION_CAP: prdata = {19'd0, r_correction_cap};
            REG_SWAY_GAIN:      prdata = {16'd0, r_sway_gain};
            REG_DRIVE_BOOST:    prdata = {16'd0, r_drive_boost};
            default:            prdata = 32'd0;
        endcase
    end

    hdd_pkg::t_dp_cmd w_cmd;
    hdd_pkg::t_dp_sts w_sts;

    hdd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    hdd_datapath #(
        .ITER (CORDIC_ITERATIONS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_heading_x      (i_heading_x),
        .i_heading_y      (i_heading_y),
        .i_sway           (i_sway),
        .i_ramp_steps     (r_ramp_steps),
        .i_correction_cap (r_correction_cap),
        .i_sway_gain      (r_sway_gain),
        .i_drive_boost    (r_drive_boost),
        .o_left_drive     (o_left_drive),
        .o_right_drive    (o_right_drive)
    );

    logic w_in_acc;
    logic w_drv_ok;

    assign w_in_acc = i_in_valid && !o_in_stall;
    assign w_drv_ok = (o_left_drive <= 16'd32768) && (o_right_drive <= 16'd32768);

    // An accepted transaction keeps the block busy for the following cycle.
    `HDD_ASSERT_NEXT(a_busy_after_accept, w_in_acc, o_in_stall, "not busy after accept")
    // A new result appears only as the controller returns to idle.
    `HDD_ASSERT_SAME(a_idle_on_result, $rose(o_out_valid), !o_in_stall, "result while busy")
    // Scaled drives never exceed full drive.
    `HDD_ASSERT_SAME(a_drive_range, o_out_valid, w_drv_ok, "drive above full")

endmodule
